// File: hw/rtl/dahr_pkg.sv
package dahr_pkg;

    // ring and decimation limits
    localparam int RingDepth     = 64;
    localparam int MaxDecimation = 1024;

    // field widths
    localparam int SampleW  = 16;
    localparam int DecW     = 11;
    localparam int LenW     = 7;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = (DecW > LenW) ? DecW : LenW;

    // derived widths
    localparam int IdxW     = $clog2(RingDepth);
    localparam int FillW    = $clog2(RingDepth + 1);
    localparam int CountW   = (MaxDecimation > 1) ? $clog2(MaxDecimation) : 1;
    localparam int DivW     = CountW + 1;
    localparam int TotalW   = SampleW + CountW;
    localparam int SumW     = SampleW + IdxW;
    localparam int DivSteps = TotalW;
    localparam int StepW    = $clog2(DivSteps + 1);

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CfgDecimation = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgRingLength = 2'd1;

    typedef enum logic [1:0] {
        StIdle,
        StDivide,
        StUpdate,
        StEmit
    } state_t;

endpackage

// File: hw/rtl/decimating_average_history_ring.sv
// Decimating average with a history ring.
//
// Input channel: one unsigned 16-bit sample per word on in_valid/in_ready.
// Output channel: exactly one result word per sample on out_valid/out_ready,
// giving the ring fill count, the sum of the ring entries, and whether this
// sample completed an average together with the average that was pushed.
// Configuration: cfg_we with cfg_index 0 writes decimation_count, index 1
// writes ring_length; either write also clears the accumulator and the ring.
// Sequence: a sample that does not complete an average goes from acceptance
// straight to the emit state. A sample that completes one runs the restoring
// divider, one quotient bit per cycle over the 26-bit total, then a ring
// update state, before its result is loaded. The divider and the ring memory
// serve one sample at a time: no new sample is taken until the last result
// has been loaded into the output register.
// Reset clears the accumulator, fill count, ring pointers and running sum;
// the ring memory itself is not cleared and its read data is only used where written.
// A stalled receiver holds the result in the output register; the next
// sample is still taken and waits for that register to drain.
module decimating_average_history_ring (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [dahr_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [dahr_pkg::CfgDataW-1:0]  cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [dahr_pkg::SampleW-1:0]   sample,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [dahr_pkg::FillW-1:0]     fill_count,
    output logic [dahr_pkg::SumW-1:0]      window_sum,
    output logic                           pushed,
    output logic [dahr_pkg::SampleW-1:0]   pushed_average
);
    import dahr_pkg::*;

    // control state
    state_t              state_reg, state_next;
    logic [DecW-1:0]     dec_reg, dec_next;
    logic [LenW-1:0]     len_reg, len_next;
    logic [CountW-1:0]   count_reg, count_next;
    logic [TotalW-1:0]   total_reg, total_next;
    logic [FillW-1:0]    held_reg, held_next;
    logic [IdxW-1:0]     oldest_reg, oldest_next;
    logic [IdxW-1:0]     newest_reg, newest_next;
    logic [SumW-1:0]     sum_reg, sum_next;
    logic                push_reg, push_next;
    logic [SampleW-1:0]  avg_reg, avg_next;
    logic [StepW-1:0]    step_reg, step_next;
    logic [DivW-1:0]     rem_reg, rem_next;
    logic [TotalW-1:0]   quo_reg, quo_next;
    logic                out_valid_reg, out_valid_next;
    logic [FillW-1:0]    out_fill_reg;
    logic [SumW-1:0]     out_sum_reg;
    logic                out_push_reg;
    logic [SampleW-1:0]  out_avg_reg;
    logic                out_load;

    // ring memory
    logic [SampleW-1:0]  store_mem [RingDepth];
    logic [SampleW-1:0]  rd_data_reg;
    logic                mem_rd;
    logic                mem_wr;
    logic [IdxW-1:0]     mem_waddr;

    // working values
    logic [DivW-1:0]     dec_eff;
    logic [FillW-1:0]    len_eff;
    logic [DivW-1:0]     count_inc;
    logic [TotalW-1:0]   total_inc;
    logic                accept;
    logic                cfg_hit;
    logic [DivW:0]       trial;
    logic                trial_ge;
    logic [FillW-1:0]    newest_inc;
    logic [FillW-1:0]    oldest_inc;
    logic [SumW-1:0]     sum_less;

    // effective register values, out-of-range codes clamped
    always_comb
    begin
        if (dec_reg == '0)
            dec_eff = DivW'(1);
        else if (int'(dec_reg) > MaxDecimation)
            dec_eff = DivW'(MaxDecimation);
        else
            dec_eff = DivW'(dec_reg);

        if (len_reg == '0)
            len_eff = FillW'(1);
        else if (int'(len_reg) > RingDepth)
            len_eff = FillW'(RingDepth);
        else
            len_eff = FillW'(len_reg);
    end

    assign accept     = in_valid && in_ready;
    assign cfg_hit    = cfg_we && (cfg_index == CfgDecimation || cfg_index == CfgRingLength);
    assign count_inc  = {1'b0, count_reg} + DivW'(1);
    assign total_inc  = total_reg + TotalW'(sample);
    assign trial      = {rem_reg, quo_reg[TotalW-1]};
    assign trial_ge   = trial >= {1'b0, dec_eff};
    assign newest_inc = FillW'(newest_reg) + FillW'(1);
    assign oldest_inc = FillW'(oldest_reg) + FillW'(1);
    assign sum_less   = sum_reg - SumW'(rd_data_reg);

    // next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        dec_next       = dec_reg;
        len_next       = len_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        held_next      = held_reg;
        oldest_next    = oldest_reg;
        newest_next    = newest_reg;
        sum_next       = sum_reg;
        push_next      = push_reg;
        avg_next       = avg_reg;
        step_next      = step_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_load       = 1'b0;
        in_ready       = (state_reg == StIdle);
        mem_rd         = 1'b0;
        mem_wr         = 1'b0;
        mem_waddr      = newest_reg;

        case (state_reg)
            StIdle:
            begin
                if (accept)
                begin
                    mem_rd = 1'b1;
                    if (count_inc >= dec_eff)
                    begin
                        // average complete: divide the total
                        count_next = '0;
                        total_next = '0;
                        push_next  = 1'b1;
                        quo_next   = total_inc;
                        rem_next   = '0;
                        step_next  = '0;
                        state_next = StDivide;
                    end
                    else
                    begin
                        count_next = count_inc[CountW-1:0];
                        total_next = total_inc;
                        push_next  = 1'b0;
                        avg_next   = '0;
                        state_next = StEmit;
                    end
                end
            end
            StDivide:
            begin
                // one restoring step per cycle
                if (trial_ge)
                    rem_next = DivW'(trial - {1'b0, dec_eff});
                else
                    rem_next = trial[DivW-1:0];
                quo_next  = {quo_reg[TotalW-2:0], trial_ge};
                step_next = step_reg + StepW'(1);
                if (step_reg == StepW'(DivSteps - 1))
                    state_next = StUpdate;
            end
            StUpdate:
            begin
                // advance the ring and write the new average
                avg_next = quo_reg[SampleW-1:0];
                if (held_reg != '0)
                begin
                    if (newest_inc >= len_eff)
                        newest_next = '0;
                    else
                        newest_next = newest_inc[IdxW-1:0];
                    if (held_reg >= len_eff)
                    begin
                        sum_next = sum_less + SumW'(quo_reg[SampleW-1:0]);
                        if (oldest_inc >= len_eff)
                            oldest_next = '0;
                        else
                            oldest_next = oldest_inc[IdxW-1:0];
                    end
                    else
                    begin
                        sum_next  = sum_reg + SumW'(quo_reg[SampleW-1:0]);
                        held_next = held_reg + FillW'(1);
                    end
                end
                else
                begin
                    sum_next  = sum_reg + SumW'(quo_reg[SampleW-1:0]);
                    held_next = FillW'(1);
                end
                mem_wr     = 1'b1;
                mem_waddr  = newest_next;
                state_next = StEmit;
            end
            StEmit:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = StIdle;
                end
            end
            default:
            begin
                state_next = StIdle;
            end
        endcase

        // configuration write clears the accumulator and the ring
        if (cfg_hit)
        begin
            if (cfg_index == CfgDecimation)
                dec_next = cfg_data[DecW-1:0];
            else
                len_next = cfg_data[LenW-1:0];
            count_next  = '0;
            total_next  = '0;
            held_next   = '0;
            oldest_next = '0;
            newest_next = '0;
            sum_next    = '0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= StIdle;
            dec_reg       <= DecW'(1);
            len_reg       <= LenW'(RingDepth);
            count_reg     <= '0;
            total_reg     <= '0;
            held_reg      <= '0;
            oldest_reg    <= '0;
            newest_reg    <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dec_reg       <= dec_next;
            len_reg       <= len_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            held_reg      <= held_next;
            oldest_reg    <= oldest_next;
            newest_reg    <= newest_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // divider and result payload
    always_ff @(posedge clk)
    begin
        push_reg <= push_next;
        avg_reg  <= avg_next;
        step_reg <= step_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        if (out_load)
        begin
            out_fill_reg <= held_reg;
            out_sum_reg  <= sum_reg;
            out_push_reg <= push_reg;
            out_avg_reg  <= avg_reg;
        end
    end

    // ring memory, oldest entry read as the sample is taken
    always_ff @(posedge clk)
    begin
        if (mem_wr)
            store_mem[mem_waddr] <= quo_reg[SampleW-1:0];
        if (mem_rd)
            rd_data_reg <= store_mem[oldest_reg];
    end

    assign out_valid      = out_valid_reg;
    assign fill_count     = out_fill_reg;
    assign window_sum     = out_sum_reg;
    assign pushed         = out_push_reg;
    assign pushed_average = out_avg_reg;

    // fill count never passes the ring length in use
    assert property (@(posedge clk) disable iff (!rst_n) held_reg <= len_eff)
        else $error("ring fill count above ring length");

    // pointers stay inside the ring in use
    assert property (@(posedge clk) disable iff (!rst_n)
        (FillW'(oldest_reg) < len_eff) && (FillW'(newest_reg) < len_eff))
        else $error("ring pointer outside ring length");

    // a word without a push carries a zero average
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_push_reg |-> out_avg_reg == '0)
        else $error("average given without a push");

    // the divider always hands over to the ring update
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == StDivide && step_reg == StepW'(DivSteps - 1) |=> state_reg == StUpdate)
        else $error("divider did not finish into ring update");

endmodule
